/* sv/stf_pkg.sv */
// Shared types and constants of the SLIP transmit framer.
package stf_pkg;

  localparam int TX_BUF_DEPTH_DEF = 1024;

  localparam int NUM_SLOTS  = 3;  // store writes one item can cause
  localparam int NUM_BANKS  = 4;  // store banks, selected by position bits [1:0]
  localparam int LOW_BYTES  = 2;  // positions held in flops instead of the banks

  localparam logic [7:0] SLIP_END     = 8'hC0;
  localparam logic [7:0] SLIP_ESC     = 8'hDB;
  localparam logic [7:0] SLIP_ESC_END = 8'hDC;
  localparam logic [7:0] SLIP_ESC_ESC = 8'hDD;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_DONE  = 2'd1,
    ACT_READ  = 2'd2,
    ACT_NONE  = 2'd3
  } action_t;

  typedef struct packed {
    logic        start_transmit;
    logic [9:0]  chunk_start;
    logic [10:0] chunk_length;
    logic [15:0] pending_bytes;
    logic        overflow;
  } stf_status_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] wr_en;
    logic                 rd_en;
  } stf_store_req_t;

endpackage

/* sv/stf_if.sv */
// Channel interfaces of the SLIP transmit framer: input items, results, configuration.
interface stf_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] action;
  logic [7:0] data_byte;
  logic       frame_last;
  logic [9:0] read_index;

  modport source (output valid, action, data_byte, frame_last, read_index, input ready);
  modport sink   (input valid, action, data_byte, frame_last, read_index, output ready);
endinterface

interface stf_out_if;
  logic        valid;
  logic        ready;
  logic        start_transmit;
  logic [9:0]  chunk_start;
  logic [10:0] chunk_length;
  logic [15:0] pending_bytes;
  logic        overflow;
  logic [7:0]  read_data;

  modport source (output valid, start_transmit, chunk_start, chunk_length, pending_bytes,
                  overflow, read_data, input ready);
  modport sink   (input valid, start_transmit, chunk_start, chunk_length, pending_bytes,
                  overflow, read_data, output ready);
endinterface

interface stf_cfg_if;
  logic valid;
  logic ready;
  logic slip_mode;

  modport source (output valid, slip_mode, input ready);
  modport sink   (input valid, slip_mode, output ready);
endinterface

/* sv/stf_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module stf_ram #(
  parameter int WIDTH  = 8,
  parameter int DEPTH  = 256,
  parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [WIDTH-1:0]  wdata,
  input  logic              re,
  input  logic [ADDR_W-1:0] raddr,
  output logic [WIDTH-1:0]  rd_data_r
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rd_data_r <= mem_r[raddr];
    end
  end

endmodule

/* sv/stf_store.sv */
// Circular transmit store: four banks by position bits [1:0], positions 0 and 1 in flops.
module stf_store #(
  parameter int DEPTH = stf_pkg::TX_BUF_DEPTH_DEF,
  parameter int POS_W = $clog2(DEPTH)
) (
  input  logic                   clk,
  input  stf_pkg::stf_store_req_t req,
  input  logic [POS_W-1:0]       wr_pos  [stf_pkg::NUM_SLOTS],
  input  logic [7:0]             wr_data [stf_pkg::NUM_SLOTS],
  input  logic [9:0]             rd_index,
  output logic [7:0]             rd_data
);
  import stf_pkg::*;

  localparam int BANK_DEPTH = (DEPTH + NUM_BANKS - 1) / NUM_BANKS;
  localparam int BANK_AW    = (BANK_DEPTH > 1) ? $clog2(BANK_DEPTH) : 1;

  logic               bank_we    [NUM_BANKS];
  logic [BANK_AW-1:0] bank_waddr [NUM_BANKS];
  logic [7:0]         bank_wdata [NUM_BANKS];
  logic [7:0]         bank_rdata [NUM_BANKS];
  logic [BANK_AW-1:0] bank_raddr;

  logic [7:0] low_byte_r [LOW_BYTES];

  logic       rd_in_range_r;
  logic       rd_low_r;
  logic [7:0] rd_low_byte_r;
  logic [1:0] rd_bank_r;

  // Route each slot to the bank its position selects; the slots of one item never
  // share a bank, since wrap-around always lands in the flop-held positions.
  always_comb begin
    for (int b = 0; b < NUM_BANKS; b++) begin
      bank_we[b]    = 1'b0;
      bank_waddr[b] = '0;
      bank_wdata[b] = '0;
      for (int k = 0; k < NUM_SLOTS; k++) begin
        if (req.wr_en[k] && (wr_pos[k] >= POS_W'(LOW_BYTES)) && (wr_pos[k][1:0] == 2'(b))) begin
          bank_we[b]    = 1'b1;
          bank_waddr[b] = BANK_AW'(wr_pos[k] >> 2);
          bank_wdata[b] = wr_data[k];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      if (req.wr_en[k] && (wr_pos[k] < POS_W'(LOW_BYTES))) begin
        low_byte_r[wr_pos[k][0]] <= wr_data[k];
      end
    end
  end

  assign bank_raddr = BANK_AW'(rd_index >> 2);

  for (genvar g = 0; g < NUM_BANKS; g++) begin : g_bank
    stf_ram #(
      .WIDTH (8),
      .DEPTH (BANK_DEPTH),
      .ADDR_W(BANK_AW)
    ) u_bank (
      .clk      (clk),
      .we       (bank_we[g]),
      .waddr    (bank_waddr[g]),
      .wdata    (bank_wdata[g]),
      .re       (req.rd_en),
      .raddr    (bank_raddr),
      .rd_data_r(bank_rdata[g])
    );
  end

  // Hold the read selection alongside the bank outputs.
  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      rd_in_range_r <= (32'(rd_index) < 32'(DEPTH));
      rd_low_r      <= (rd_index < 10'(LOW_BYTES));
      rd_low_byte_r <= low_byte_r[rd_index[0]];
      rd_bank_r     <= rd_index[1:0];
    end
  end

  always_comb begin
    if (!rd_in_range_r) begin
      rd_data = '0;
    end else if (rd_low_r) begin
      rd_data = rd_low_byte_r;
    end else begin
      rd_data = bank_rdata[rd_bank_r];
    end
  end

endmodule

/* sv/stf_ctrl.sv */
// SLIP encoding, store positions, pending count and chunk launch state.
module stf_ctrl #(
  parameter int DEPTH = stf_pkg::TX_BUF_DEPTH_DEF,
  parameter int POS_W = $clog2(DEPTH)
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    accept,
  input  logic [1:0]              action,
  input  logic [7:0]              data_byte,
  input  logic                    frame_last,
  input  logic                    slip_mode,
  output stf_pkg::stf_store_req_t req,
  output logic [POS_W-1:0]        wr_pos  [stf_pkg::NUM_SLOTS],
  output logic [7:0]              wr_data [stf_pkg::NUM_SLOTS],
  output stf_pkg::stf_status_t    status
);
  import stf_pkg::*;

  localparam int PW = $clog2(DEPTH + 1);  // write_pos and chunk length reach DEPTH

  typedef struct packed {
    logic          busy;
    logic [PW-1:0] len;
  } launch_t;

  function automatic logic [POS_W-1:0] wrap_pos(input logic [PW-1:0] p);
    return (32'(p) >= 32'(DEPTH)) ? '0 : POS_W'(p);
  endfunction

  // Cut the chunk at the end of the store.
  function automatic launch_t launch(input logic [15:0] pc, input logic [POS_W-1:0] rp);
    launch_t l;
    l.busy = (pc != 16'd0);
    if (pc == 16'd0) begin
      l.len = '0;
    end else if ((32'(pc) + 32'(rp)) >= 32'(DEPTH)) begin
      l.len = PW'(32'(DEPTH) - 32'(rp));
    end else begin
      l.len = PW'(pc);
    end
    return l;
  endfunction

  logic [PW-1:0]    write_pos_r, write_pos_nxt;
  logic [POS_W-1:0] read_pos_r, read_pos_nxt;
  logic [15:0]      pending_r, pending_nxt;
  logic [PW-1:0]    chunk_len_r, chunk_len_nxt;
  logic             link_idle_r, link_idle_nxt;
  logic             started;

  logic [7:0]       enc_byte [NUM_SLOTS];
  logic [1:0]       enc_cnt;
  logic [POS_W-1:0] pos [NUM_SLOTS];
  logic [PW-1:0]    rp_sum;
  logic [POS_W-1:0] rp_done;
  logic [15:0]      pend_write;
  logic [15:0]      pend_done;
  launch_t          l_write;
  launch_t          l_done;

  // In SLIP mode escape END and ESC and append END at frame end; raw mode copies the byte.
  always_comb begin
    enc_byte[0] = data_byte;
    enc_byte[1] = SLIP_END;
    enc_byte[2] = SLIP_END;
    enc_cnt     = 2'd1;
    if (slip_mode && (data_byte == SLIP_END)) begin
      enc_byte[0] = SLIP_ESC;
      enc_byte[1] = SLIP_ESC_END;
      enc_cnt     = 2'd2;
    end else if (slip_mode && (data_byte == SLIP_ESC)) begin
      enc_byte[0] = SLIP_ESC;
      enc_byte[1] = SLIP_ESC_ESC;
      enc_cnt     = 2'd2;
    end
    if (slip_mode && frame_last) begin
      enc_cnt = enc_cnt + 2'd1;
    end
  end

  always_comb begin
    pos[0] = wrap_pos(write_pos_r);
    pos[1] = wrap_pos(PW'(pos[0]) + PW'(1));
    pos[2] = wrap_pos(PW'(pos[1]) + PW'(1));
  end

  assign pend_write = pending_r + 16'(enc_cnt);
  assign pend_done  = pending_r - 16'(chunk_len_r);
  assign rp_sum     = PW'(read_pos_r) + chunk_len_r;
  assign rp_done    = (32'(rp_sum) >= 32'(DEPTH)) ? '0 : POS_W'(rp_sum);
  assign l_write    = launch(pend_write, read_pos_r);
  assign l_done     = launch(pend_done, rp_done);

  always_comb begin
    write_pos_nxt = write_pos_r;
    read_pos_nxt  = read_pos_r;
    pending_nxt   = pending_r;
    chunk_len_nxt = chunk_len_r;
    link_idle_nxt = link_idle_r;
    started       = 1'b0;
    unique case (action_t'(action))
      ACT_WRITE: begin
        unique case (enc_cnt)
          2'd1:    write_pos_nxt = PW'(pos[0]) + PW'(1);
          2'd2:    write_pos_nxt = PW'(pos[1]) + PW'(1);
          default: write_pos_nxt = PW'(pos[2]) + PW'(1);
        endcase
        pending_nxt = pend_write;
        if (link_idle_r) begin
          chunk_len_nxt = l_write.len;
          link_idle_nxt = !l_write.busy;
          started       = l_write.busy;
        end
      end
      ACT_DONE: begin
        pending_nxt   = pend_done;
        read_pos_nxt  = rp_done;
        chunk_len_nxt = l_done.len;
        link_idle_nxt = !l_done.busy;
        started       = l_done.busy;
      end
      ACT_READ: begin
      end
      ACT_NONE: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      write_pos_r <= '0;
      read_pos_r  <= '0;
      pending_r   <= '0;
      chunk_len_r <= '0;
      link_idle_r <= 1'b1;
    end else if (accept) begin
      write_pos_r <= write_pos_nxt;
      read_pos_r  <= read_pos_nxt;
      pending_r   <= pending_nxt;
      chunk_len_r <= chunk_len_nxt;
      link_idle_r <= link_idle_nxt;
    end
  end

  always_comb begin
    for (int k = 0; k < NUM_SLOTS; k++) begin
      req.wr_en[k] = accept && (action_t'(action) == ACT_WRITE) && (2'(k) < enc_cnt);
      wr_pos[k]    = pos[k];
      wr_data[k]   = enc_byte[k];
    end
    req.rd_en = accept && (action_t'(action) == ACT_READ);
  end

  assign status.start_transmit = started;
  assign status.chunk_start    = 10'(read_pos_nxt);
  assign status.chunk_length   = 11'(chunk_len_nxt);
  assign status.pending_bytes  = pending_nxt;
  assign status.overflow       = (32'(pending_nxt) > 32'(DEPTH));

endmodule

/* sv/slip_tx_framer_ring.sv */
// Top level of the SLIP transmit framer with its circular transmit store.
//
// Usage:
//   in_ch  : one transfer per action - write a payload byte (escaped and framed
//            in SLIP mode, copied as it is in raw mode), retire the current chunk,
//            or read back a stored byte.
//   out_ch : exactly one result transfer per input transfer, in order: chunk
//            start flag, chunk position and length, pending count, overflow flag
//            and the read byte (zero for anything but an in-range read).
//   cfg_ch : slip_mode, always ready; write it only while the block is idle.
// One item is taken every cycle while the receiver keeps up with the results. The
// input transfer drives the store writes and state update; the middle stage holds
// the status beside the store read, the result register until taken.
// The store is four banks with one write and one read port each, interleaved on
// position bits [1:0], with positions 0 and 1 in flops, so the up to three bytes
// of one item land in the same cycle.
// Reset (rst_n low, synchronous) empties the pipeline, clears positions and the
// pending count, frees the link and selects SLIP mode; the store is left as is.
// When the receiver stalls, results hold in the output and middle stages and
// in_ch.ready drops once both are full.
module slip_tx_framer_ring #(
  parameter int TX_BUF_DEPTH = stf_pkg::TX_BUF_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  stf_in_if.sink      in_ch,
  stf_out_if.source   out_ch,
  stf_cfg_if.sink     cfg_ch
);
  import stf_pkg::*;

  localparam int POS_W = $clog2(TX_BUF_DEPTH);

  logic           slip_mode_r;
  logic           accept;
  logic           out_en;
  logic           s1_en;

  stf_store_req_t store_req;
  logic [POS_W-1:0] wr_pos  [NUM_SLOTS];
  logic [7:0]       wr_data [NUM_SLOTS];
  logic [7:0]       rd_data;
  stf_status_t      status;

  // middle stage: status beside the registered store read
  logic        s1_vld_r;
  logic        s1_rd_r;
  stf_status_t s1_stat_r;

  // result register
  logic        out_vld_r;
  stf_status_t out_stat_r;
  logic [7:0]  out_rdata_r, out_rdata_nxt;

  // Configuration: take every write at once.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slip_mode_r <= 1'b1;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      slip_mode_r <= cfg_ch.slip_mode;
    end
  end

  // Advance a stage when the one after it is empty or moving.
  assign out_en      = !out_vld_r || out_ch.ready;
  assign s1_en       = !s1_vld_r || out_en;
  assign in_ch.ready = s1_en;
  assign accept      = in_ch.valid && in_ch.ready;

  stf_ctrl #(
    .DEPTH(TX_BUF_DEPTH),
    .POS_W(POS_W)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .action    (in_ch.action),
    .data_byte (in_ch.data_byte),
    .frame_last(in_ch.frame_last),
    .slip_mode (slip_mode_r),
    .req       (store_req),
    .wr_pos    (wr_pos),
    .wr_data   (wr_data),
    .status    (status)
  );

  stf_store #(
    .DEPTH(TX_BUF_DEPTH),
    .POS_W(POS_W)
  ) u_store (
    .clk     (clk),
    .req     (store_req),
    .wr_pos  (wr_pos),
    .wr_data (wr_data),
    .rd_index(in_ch.read_index),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (s1_en) begin
      s1_vld_r <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_en) begin
      s1_stat_r <= status;
      s1_rd_r   <= store_req.rd_en;
    end
  end

  // Drop the store output for anything but a read.
  assign out_rdata_nxt = s1_rd_r ? rd_data : 8'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (out_en) begin
      out_vld_r <= s1_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_en) begin
      out_stat_r  <= s1_stat_r;
      out_rdata_r <= out_rdata_nxt;
    end
  end

  assign out_ch.valid          = out_vld_r;
  assign out_ch.start_transmit = out_stat_r.start_transmit;
  assign out_ch.chunk_start    = out_stat_r.chunk_start;
  assign out_ch.chunk_length   = out_stat_r.chunk_length;
  assign out_ch.pending_bytes  = out_stat_r.pending_bytes;
  assign out_ch.overflow       = out_stat_r.overflow;
  assign out_ch.read_data      = out_rdata_r;

  // A started chunk always carries bytes.
  a_start_has_len: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && out_ch.start_transmit && (TX_BUF_DEPTH <= 1024)) |->
      (out_ch.chunk_length != 11'd0))
    else $error("chunk started with zero length");

  // A chunk never runs past the end of the store.
  a_chunk_in_store: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && (TX_BUF_DEPTH <= 1024)) |->
      ((32'(out_ch.chunk_start) + 32'(out_ch.chunk_length)) <= 32'(TX_BUF_DEPTH)))
    else $error("chunk crosses the end of the store");

  // The middle stage holds while the result register cannot take it.
  a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_vld_r && !out_en) |=> (s1_vld_r && $stable(s1_stat_r) && $stable(s1_rd_r)))
    else $error("middle stage changed while stalled");

endmodule
